FILE: src/lbpu_pkg.sv
// package for the lsb-first bit packer / unpacker
// holds item codes, field widths and the controller/datapath command and status types
// no dependencies
package lbpu_pkg;

    localparam int DEF_CAPACITY_BYTES = 4096;
    localparam int MAX_BITS           = 32;

    localparam int KIND_W  = 2;
    localparam int COUNT_W = 6;
    localparam int VALUE_W = 32;

    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       wr_en;
        logic       rd_en;
        logic       upd;
        logic       load_out;
        logic [2:0] slot;
    } cmd_t;

    typedef struct packed {
        logic       do_write;
        logic       do_read;
        logic [2:0] nbytes;
    } status_t;

endpackage

FILE: src/lbpu_if.sv
// valid/ready channel interfaces for the bit packer / unpacker
// depends on lbpu_pkg for field widths
interface lbpu_req_if import lbpu_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [COUNT_W-1:0] bit_count;
    logic               sign_extend;
    logic [VALUE_W-1:0] write_value;

    modport source (output valid, output kind, output bit_count, output sign_extend,
                    output write_value, input ready);
    modport sink (input valid, input kind, input bit_count, input sign_extend,
                  input write_value, output ready);
endinterface

interface lbpu_rsp_if import lbpu_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] read_value;
    logic               read_in_range;
    logic               more_data;
    logic               overflow;

    modport source (output valid, output read_value, output read_in_range,
                    output more_data, output overflow, input ready);
    modport sink (input valid, input read_value, input read_in_range,
                  input more_data, input overflow, output ready);
endinterface

FILE: src/lbpu_ctrl.sv
// controller state machine: item handshake, byte loop sequencing, result handoff
// depends on lbpu_pkg for cmd_t and status_t
module lbpu_ctrl import lbpu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       last;

    assign last = (cnt_reg == (status.nbytes - 3'd1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.slot   = cnt_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = 3'd0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (status.do_write || status.do_read)
                begin
                    cmd.wr_en = status.do_write;
                    cmd.rd_en = status.do_read;
                    if (last)
                    begin
                        state_next = S_UPD;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                else
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_no_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_en && cmd.rd_en))
        else $error("read and write issued together");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en || cmd.rd_en) |-> (cmd.slot < status.nbytes))
        else $error("byte slot beyond span");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");
`endif

endmodule

FILE: src/lbpu_dp.sv
// datapath: cursors, length, tail byte, byte store, bit alignment and result register
// depends on lbpu_pkg for codes, widths, cmd_t and status_t
module lbpu_dp import lbpu_pkg::*;
#(
    parameter int CAPACITY_BYTES = DEF_CAPACITY_BYTES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [KIND_W-1:0]  kind,
    input  logic [COUNT_W-1:0] bit_count,
    input  logic               sign_extend,
    input  logic [VALUE_W-1:0] write_value,
    output logic [VALUE_W-1:0] read_value,
    output logic               read_in_range,
    output logic               more_data,
    output logic               overflow
);

    localparam int BIT_W = $clog2(CAPACITY_BYTES * 8 + 1);
    localparam int LEN_W = $clog2(CAPACITY_BYTES + 1);
    localparam int AW    = $clog2(CAPACITY_BYTES);
    localparam int END_W = BIT_W + 1;
    localparam logic [END_W-1:0] LIMIT = END_W'(CAPACITY_BYTES * 8);

    // architectural state
    logic [BIT_W-1:0] wcur_reg, wcur_next;
    logic [BIT_W-1:0] rcur_reg, rcur_next;
    logic [LEN_W-1:0] blen_reg, blen_next;
    logic [7:0]       tail_reg, tail_next;

    // per item plan
    logic [KIND_W-1:0]  kind_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic               sext_reg;
    logic               ovf_reg;
    logic               inr_reg;
    logic [2:0]         nb_reg;
    logic [2:0]         off_reg;
    logic [2:0]         tidx_reg;
    logic [AW-1:0]      base_reg;
    logic [END_W-1:0]   wend_reg;
    logic [END_W-1:0]   rend_reg;
    logic [39:0]        word_reg;
    logic [39:0]        gather_reg;

    // byte store
    logic [7:0] mem [CAPACITY_BYTES];
    logic [7:0] mem_q_reg;
    logic       rd_vld_reg;
    logic [2:0] rd_slot_reg;
    logic [AW-1:0] addr;

    // result register
    logic [VALUE_W-1:0] rval_reg;
    logic               inr_out_reg;
    logic               more_reg;
    logic               ovf_out_reg;

    // accept-time plan
    logic [COUNT_W-1:0] cnt_sat;
    logic [32:0]        in_mask;
    logic [END_W-1:0]   wend_c;
    logic [END_W-1:0]   rend_c;
    logic [END_W-1:0]   rup_c;
    logic               inr_c;
    logic               ovf_c;
    logic [2:0]         off_c;
    logic [5:0]         span_c;
    logic [5:0]         nb_span_c;
    logic [39:0]        word_c;
    logic [AW-1:0]      base_c;

    always_comb
    begin
        cnt_sat   = (bit_count > COUNT_W'(MAX_BITS)) ? COUNT_W'(MAX_BITS) : bit_count;
        in_mask   = (33'd1 << cnt_sat) - 33'd1;
        wend_c    = END_W'(wcur_reg) + END_W'(cnt_sat);
        rend_c    = END_W'(rcur_reg) + END_W'(cnt_sat);
        rup_c     = rend_c + END_W'(7);
        inr_c     = (rup_c >> 3) <= END_W'(blen_reg);
        ovf_c     = wend_c > LIMIT;
        off_c     = (kind == KIND_READ) ? rcur_reg[2:0] : wcur_reg[2:0];
        span_c    = 6'(off_c) + cnt_sat;
        nb_span_c = (span_c + 6'd7) >> 3;
        word_c    = ({8'd0, write_value & in_mask[31:0]} << wcur_reg[2:0])
                    | {32'd0, tail_reg};
        base_c    = (kind == KIND_READ) ? rcur_reg[3 +: AW] : wcur_reg[3 +: AW];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            cnt_reg  <= cnt_sat;
            sext_reg <= sign_extend;
            ovf_reg  <= ovf_c;
            inr_reg  <= inr_c;
            nb_reg   <= nb_span_c[2:0];
            off_reg  <= off_c;
            tidx_reg <= span_c[5:3];
            base_reg <= base_c;
            wend_reg <= wend_c;
            rend_reg <= rend_c;
            word_reg <= word_c;
        end
    end

    assign status.do_write = (kind_reg == KIND_APPEND) && !ovf_reg && (nb_reg != 3'd0);
    assign status.do_read  = (kind_reg == KIND_READ) && inr_reg && (nb_reg != 3'd0);
    assign status.nbytes   = nb_reg;

    assign addr = base_reg + AW'(cmd.slot);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[addr] <= word_reg[{cmd.slot, 3'b000} +: 8];
        end
        if (cmd.rd_en)
        begin
            mem_q_reg <= mem[addr];
        end
        rd_slot_reg <= cmd.slot;
        if (rd_vld_reg)
        begin
            gather_reg[{rd_slot_reg, 3'b000} +: 8] <= mem_q_reg;
        end
    end

    // state update
    logic [END_W-1:0] wup;

    always_comb
    begin
        wcur_next = wcur_reg;
        rcur_next = rcur_reg;
        blen_next = blen_reg;
        tail_next = tail_reg;
        wup       = wend_reg + END_W'(7);
        if (cmd.upd)
        begin
            case (kind_reg)
                KIND_APPEND:
                begin
                    if (!ovf_reg)
                    begin
                        wcur_next = wend_reg[BIT_W-1:0];
                        blen_next = LEN_W'(wup >> 3);
                        tail_next = word_reg[{tidx_reg, 3'b000} +: 8];
                    end
                end
                KIND_READ:
                begin
                    rcur_next = (rend_reg > LIMIT) ? LIMIT[BIT_W-1:0] : rend_reg[BIT_W-1:0];
                end
                KIND_CLEAR:
                begin
                    wcur_next = '0;
                    rcur_next = '0;
                    blen_next = '0;
                    tail_next = 8'd0;
                end
                default:
                begin
                    wcur_next = wcur_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcur_reg   <= '0;
            rcur_reg   <= '0;
            blen_reg   <= '0;
            tail_reg   <= 8'd0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            wcur_reg   <= wcur_next;
            rcur_reg   <= rcur_next;
            blen_reg   <= blen_next;
            tail_reg   <= tail_next;
            rd_vld_reg <= cmd.rd_en;
        end
    end

    // result alignment
    logic [39:0]        sh;
    logic [32:0]        rmask;
    logic [VALUE_W-1:0] v;
    logic [4:0]         sidx;
    logic               sgn;
    logic [VALUE_W-1:0] val;
    logic               is_rd;
    logic               more_c;

    always_comb
    begin
        sh     = gather_reg >> off_reg;
        rmask  = (33'd1 << cnt_reg) - 33'd1;
        v      = sh[31:0] & rmask[31:0];
        sidx   = 5'(cnt_reg - COUNT_W'(1));
        sgn    = sext_reg && (cnt_reg != '0) && v[sidx];
        val    = sgn ? (v | ~rmask[31:0]) : v;
        is_rd  = (kind_reg == KIND_READ) && inr_reg;
        more_c = ((END_W'(rcur_reg) + END_W'(7)) >> 3) <= END_W'(blen_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            rval_reg    <= is_rd ? val : '0;
            inr_out_reg <= is_rd;
            more_reg    <= more_c;
            ovf_out_reg <= (kind_reg == KIND_APPEND) && ovf_reg;
        end
    end

    assign read_value    = rval_reg;
    assign read_in_range = inr_out_reg;
    assign more_data     = more_reg;
    assign overflow      = ovf_out_reg;

`ifndef SYNTHESIS
    a_len_tracks_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        blen_reg == LEN_W'((END_W'(wcur_reg) + END_W'(7)) >> 3))
        else $error("byte length out of step with write cursor");

    a_rcur_limit: assert property (@(posedge clk) disable iff (!rst_n)
        END_W'(rcur_reg) <= LIMIT)
        else $error("read cursor past limit");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.upd && (kind_reg == KIND_CLEAR)) |=> ((wcur_reg == '0) && (rcur_reg == '0)))
        else $error("clear left cursors set");
`endif

endmodule

FILE: src/lsb_first_bit_packer_unpacker.sv
// LSB-first bit packer / unpacker over a fixed-capacity byte store
// top level: joins lbpu_ctrl and lbpu_dp to the req/rsp channels
// depends on lbpu_pkg and lbpu_if
//
// usage:
//   req carries one item: kind (append, read, clear), bit_count, sign_extend, write_value
//   rsp returns exactly one result per item: read_value, read_in_range, more_data, overflow
//   bits are stored lsb first from the low bit of each byte; counts above 32 act as 32
//   an append past CAPACITY_BYTES is dropped and flagged; the read cursor saturates
// timing:
//   the result is registered once the byte loop and the state update are done, and the next
//   item is taken only after the block is back in idle; the bound is the single byte
//   port of the store, one byte per cycle for up to five bytes; req.ready high between items
// reset:
//   cursors and length go to zero at once; store contents past the length are never
//   read, so the store needs no clearing pass and items are taken right after reset
// stall:
//   a finished result waits in the output register; a new item can be taken meanwhile,
//   and the block holds in its last step only if the previous result is still unread
module lsb_first_bit_packer_unpacker import lbpu_pkg::*;
#(
    parameter int CAPACITY_BYTES = DEF_CAPACITY_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    lbpu_req_if.sink    req,
    lbpu_rsp_if.source  rsp
);

    cmd_t    cmd;
    status_t status;

    lbpu_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    lbpu_dp #(
        .CAPACITY_BYTES (CAPACITY_BYTES)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .kind          (req.kind),
        .bit_count     (req.bit_count),
        .sign_extend   (req.sign_extend),
        .write_value   (req.write_value),
        .read_value    (rsp.read_value),
        .read_in_range (rsp.read_in_range),
        .more_data     (rsp.more_data),
        .overflow      (rsp.overflow)
    );

endmodule

FILE: sim/lbpu_checker.sv
`timescale 1ns / 100ps
// checker for the lsb-first bit packer / unpacker: mirrors the byte store, cursors and length
// watches the req and rsp channels, predicts each result and compares them in order
// depends on lbpu_pkg and lbpu_if
module lbpu_checker import lbpu_pkg::*;
#(
    parameter int CAPACITY_BYTES = DEF_CAPACITY_BYTES
)
(
    input  logic clk,
    input  logic rst_n,
    lbpu_req_if  req,
    lbpu_rsp_if  rsp,
    output int   fail_count,
    output int   results_due,
    output int   results_seen,
    output int   overflow_hits,
    output int   past_end_reads,
    output int   cursor_saturations
);

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic               read_in_range;
        logic               more_data;
        logic               overflow;
    } result_t;

    logic [7:0] store_bytes [CAPACITY_BYTES];
    int         wr_bits;
    int         rd_bits;
    int         length_bytes;
    result_t    owed_results [$];

    initial
    begin
        fail_count = 0;
        results_seen = 0;
        overflow_hits = 0;
        past_end_reads = 0;
        cursor_saturations = 0;
    end

    function automatic int bits_to_bytes(input int bits);
        return (bits + 7) >> 3;
    endfunction

    task automatic clear_stream();
        int i;
        for (i = 0; i < CAPACITY_BYTES; i++)
        begin
            store_bytes[i] = 8'h00;
        end
        wr_bits = 0;
        rd_bits = 0;
        length_bytes = 0;
    endtask

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        $display("%0t: %s got %h want %h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic advance_stream(input logic [KIND_W-1:0] kind,
                                  input logic [COUNT_W-1:0] bit_count,
                                  input logic sign_extend,
                                  input logic [VALUE_W-1:0] write_value,
                                  output result_t res);
        int count;
        int stop;
        int pos;
        int i;
        res = '0;
        count = (bit_count > MAX_BITS) ? MAX_BITS : int'(bit_count);
        if (kind == KIND_APPEND)
        begin
            stop = wr_bits + count;
            if (bits_to_bytes(stop) > CAPACITY_BYTES)
            begin
                res.overflow = 1'b1;
                overflow_hits++;
            end
            else
            begin
                for (i = 0; i < count; i++)
                begin
                    pos = wr_bits + i;
                    if (write_value[i])
                        store_bytes[pos >> 3][pos & 7] = 1'b1;
                end
                wr_bits = stop;
                length_bytes = bits_to_bytes(stop);
            end
        end
        else if (kind == KIND_READ)
        begin
            stop = rd_bits + count;
            res.read_in_range = (bits_to_bytes(stop) <= length_bytes);
            if (res.read_in_range)
            begin
                for (i = 0; i < count; i++)
                begin
                    pos = rd_bits + i;
                    res.read_value[i] = store_bytes[pos >> 3][pos & 7];
                end
            end
            else
            begin
                past_end_reads++;
            end
            if (stop > CAPACITY_BYTES * 8)
            begin
                stop = CAPACITY_BYTES * 8;
                cursor_saturations++;
            end
            rd_bits = stop;
            if (sign_extend && count > 0 && count < MAX_BITS && res.read_value[count - 1])
                res.read_value = res.read_value | ({VALUE_W{1'b1}} << count);
        end
        else if (kind == KIND_CLEAR)
        begin
            clear_stream();
        end
        res.more_data = (bits_to_bytes(rd_bits) <= length_bytes);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            clear_stream();
            owed_results.delete();
            results_due <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                advance_stream(req.kind, req.bit_count, req.sign_extend, req.write_value, want);
                owed_results.push_back(want);
            end
            if (rsp.valid && rsp.ready)
            begin
                got.read_value = rsp.read_value;
                got.read_in_range = rsp.read_in_range;
                got.more_data = rsp.more_data;
                got.overflow = rsp.overflow;
                results_seen++;
                if (owed_results.size() == 0)
                begin
                    report_mismatch("result with nothing pending, read_value", got.read_value, '0);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (got.read_value !== want.read_value)
                        report_mismatch("read_value", got.read_value, want.read_value);
                    if (got.read_in_range !== want.read_in_range)
                        report_mismatch("read_in_range", VALUE_W'(got.read_in_range),
                                        VALUE_W'(want.read_in_range));
                    if (got.more_data !== want.more_data)
                        report_mismatch("more_data", VALUE_W'(got.more_data),
                                        VALUE_W'(want.more_data));
                    if (got.overflow !== want.overflow)
                        report_mismatch("overflow", VALUE_W'(got.overflow),
                                        VALUE_W'(want.overflow));
                end
            end
            results_due <= owed_results.size();
        end
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// testbench top for lsb_first_bit_packer_unpacker: clock, reset, item stimulus and verdict
// depends on lbpu_pkg, lbpu_if, lbpu_checker and the block
module tb;
    import lbpu_pkg::*;

    localparam int CAPACITY       = DEF_CAPACITY_BYTES;
    localparam int STREAM_BITS    = CAPACITY * 8;
    localparam int STALL_LIMIT    = 2000;
    localparam int BACKLOG_CYCLES = 300;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    logic calm = 1'b0;
    logic send_bursty = 1'b1;
    logic take_bursty = 1'b1;
    logic backlog_go = 1'b0;
    logic backlog_done = 1'b0;
    int   idle_cycles = 0;
    int   fail_count;
    int   results_due;
    int   results_seen;
    int   overflow_hits;
    int   past_end_reads;
    int   cursor_saturations;

    lbpu_req_if req ();
    lbpu_rsp_if rsp ();

    lsb_first_bit_packer_unpacker #(.CAPACITY_BYTES(CAPACITY)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    lbpu_checker #(.CAPACITY_BYTES(CAPACITY)) stream_mirror
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .req                (req),
        .rsp                (rsp),
        .fail_count         (fail_count),
        .results_due        (results_due),
        .results_seen       (results_seen),
        .overflow_hits      (overflow_hits),
        .past_end_reads     (past_end_reads),
        .cursor_saturations (cursor_saturations)
    );

    always #4 clk = ~clk;

    function automatic logic [COUNT_W-1:0] pick_count();
        if ($urandom_range(0, 9) == 0)
            return COUNT_W'($urandom_range(33, 63));
        return COUNT_W'($urandom_range(0, 32));
    endfunction

    task automatic offer_item(input logic [KIND_W-1:0] kind,
                              input logic [COUNT_W-1:0] bit_count,
                              input logic sign_extend,
                              input logic [VALUE_W-1:0] write_value);
        if ($urandom_range(0, 63) == 0)
            send_bursty = !send_bursty;
        if (send_bursty && !calm && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.kind <= kind;
        req.bit_count <= bit_count;
        req.sign_extend <= sign_extend;
        req.write_value <= write_value;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // receiver: random stalls, one long hold so the block backs up
    initial
    begin
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 99) == 0)
                take_bursty = !take_bursty;
            if (backlog_go && !backlog_done)
            begin
                rsp.ready <= 1'b0;
                repeat (BACKLOG_CYCLES) @(posedge clk);
                backlog_done = 1'b1;
            end
            else if (take_bursty && !calm && $urandom_range(0, 5) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        logic [COUNT_W-1:0] widths [8];
        int i;
        int n;
        int r;
        int wr_bits;
        int eff;

        rst_n = 1'b0;
        req.valid <= 1'b0;
        req.kind <= KIND_APPEND;
        req.bit_count <= '0;
        req.sign_extend <= 1'b0;
        req.write_value <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store, unused kind, extremes, saturated counts, sign extension
        offer_item(KIND_READ, 6'd0, 1'b0, 32'h0000_0000);
        offer_item(KIND_READ, 6'd8, 1'b1, 32'hFFFF_FFFF);
        offer_item(KIND_UNUSED, 6'd63, 1'b1, 32'hFFFF_FFFF);
        offer_item(KIND_CLEAR, 6'd0, 1'b0, 32'h0000_0000);
        offer_item(KIND_APPEND, 6'd32, 1'b0, 32'hFFFF_FFFF);
        offer_item(KIND_APPEND, 6'd0, 1'b0, 32'hFFFF_FFFF);
        offer_item(KIND_APPEND, 6'd1, 1'b0, 32'h0000_0001);
        offer_item(KIND_APPEND, 6'd63, 1'b0, 32'h8000_0001);
        offer_item(KIND_APPEND, 6'd33, 1'b1, 32'h0000_0000);
        offer_item(KIND_APPEND, 6'd5, 1'b0, 32'hFFFF_FFF5);
        offer_item(KIND_READ, 6'd32, 1'b1, 32'h0000_0000);
        offer_item(KIND_READ, 6'd0, 1'b1, 32'h0000_0000);
        offer_item(KIND_READ, 6'd1, 1'b1, 32'h0000_0000);
        offer_item(KIND_READ, 6'd40, 1'b0, 32'h0000_0000);
        offer_item(KIND_READ, 6'd31, 1'b1, 32'h0000_0000);
        offer_item(KIND_READ, 6'd1, 1'b1, 32'h0000_0000);
        offer_item(KIND_READ, 6'd5, 1'b1, 32'h0000_0000);
        offer_item(KIND_READ, 6'd3, 1'b0, 32'h0000_0000);
        offer_item(KIND_READ, 6'd0, 1'b0, 32'h0000_0000);
        offer_item(KIND_UNUSED, 6'd21, 1'b0, 32'h1234_5678);
        offer_item(KIND_CLEAR, 6'd63, 1'b1, 32'hFFFF_FFFF);
        offer_item(KIND_APPEND, 6'd32, 1'b0, $urandom);
        offer_item(KIND_READ, 6'd32, 1'b1, 32'h0000_0000);

        // appends read back, mostly in the same widths, with noise and clears
        backlog_go = 1'b1;
        offer_item(KIND_CLEAR, 6'd0, 1'b0, 32'h0000_0000);
        repeat (45)
        begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
            begin
                widths[i] = pick_count();
                offer_item(KIND_APPEND, widths[i], 1'($urandom_range(0, 1)), $urandom);
            end
            r = $urandom_range(0, 3);
            for (i = 0; i < n; i++)
            begin
                offer_item(KIND_READ, (r == 0) ? pick_count() : widths[i],
                           1'($urandom_range(0, 1)), $urandom);
            end
            if ($urandom_range(0, 3) == 0)
                offer_item(KIND_UNUSED, pick_count(), 1'($urandom_range(0, 1)), $urandom);
            if ($urandom_range(0, 4) == 0)
                offer_item(KIND_CLEAR, pick_count(), 1'($urandom_range(0, 1)), $urandom);
        end

        // fill to capacity, overflow, then read everything back past the end
        offer_item(KIND_CLEAR, 6'd0, 1'b0, 32'h0000_0000);
        wr_bits = 0;
        while (wr_bits + MAX_BITS <= STREAM_BITS)
        begin
            widths[0] = ($urandom_range(0, 15) == 0) ? pick_count()
                                                     : COUNT_W'($urandom_range(28, 32));
            eff = (widths[0] > MAX_BITS) ? MAX_BITS : int'(widths[0]);
            offer_item(KIND_APPEND, widths[0], 1'($urandom_range(0, 1)), $urandom);
            wr_bits += eff;
        end
        offer_item(KIND_APPEND, 6'd32, 1'b0, $urandom);
        offer_item(KIND_APPEND, COUNT_W'(STREAM_BITS - wr_bits), 1'b0, $urandom);
        offer_item(KIND_APPEND, 6'd0, 1'b0, 32'hFFFF_FFFF);
        offer_item(KIND_APPEND, 6'd1, 1'b0, 32'hFFFF_FFFF);
        offer_item(KIND_APPEND, 6'd63, 1'b1, 32'hFFFF_FFFF);
        n = STREAM_BITS / MAX_BITS + 4;
        for (i = 0; i < n; i++)
        begin
            calm = (i >= n - 300);
            offer_item(KIND_READ, 6'd32, 1'($urandom_range(0, 1)), $urandom);
        end
        offer_item(KIND_READ, 6'd0, 1'b0, 32'h0000_0000);
        offer_item(KIND_UNUSED, 6'd0, 1'b0, 32'h0000_0000);
        offer_item(KIND_CLEAR, 6'd0, 1'b0, 32'h0000_0000);
        offer_item(KIND_READ, 6'd0, 1'b0, 32'h0000_0000);
        req.valid <= 1'b0;

        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("checked %0d results: %0d appends dropped at capacity, %0d reads past the end",
                 results_seen, overflow_hits, past_end_reads);
        $display("read cursor pinned at its limit %0d times, %0d mismatches",
                 cursor_saturations, fail_count);
        if (fail_count == 0 && results_due == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
